/* sv/lrx_pkg.sv */
// ----------------------------------------------------------------------------
// lrx_pkg
// shared types, operator codes and character constants for the
// left-to-right expression evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package lrx_pkg;

  // operator codes, no precedence between them
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } lrx_op_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_PCT   = 8'h25;

  localparam int unsigned RES_WIDTH = 32;

  typedef struct packed {
    logic [7:0] symbol;
    logic       is_final;
  } lrx_in_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] value;
    logic                        div_by_zero;
  } lrx_out_t;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic    start;
    lrx_op_t op;
  } lrx_req_t;

  // status back from the shared arithmetic unit
  typedef struct packed {
    logic done;
    logic div_zero;
  } lrx_stat_t;

  function automatic lrx_op_t sym_op(input logic [7:0] symbol);
    lrx_op_t op;
    case (symbol)
      CHAR_PLUS:  op = OP_ADD;
      CHAR_MINUS: op = OP_SUB;
      CHAR_STAR:  op = OP_MUL;
      CHAR_SLASH: op = OP_DIV;
      CHAR_PCT:   op = OP_MOD;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

/* sv/lrx_alu.sv */
// ----------------------------------------------------------------------------
// lrx_alu
// iterative arithmetic unit around one shared adder: add, subtract,
// shift-add multiply and restoring divide / remainder, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lrx_alu #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lrx_pkg::lrx_req_t      req,
  input  wire logic [VALUE_WIDTH-1:0] a,
  input  wire logic [VALUE_WIDTH-1:0] b,
  output logic      [VALUE_WIDTH-1:0] result,
  output lrx_pkg::lrx_stat_t          stat
);
  import lrx_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] LastStep = CntW'(W - 1);

  typedef enum logic [2:0] {
    A_IDLE,
    A_ADD,
    A_NEGA,
    A_NEGB,
    A_LOOP,
    A_FIX,
    A_DONE
  } alu_state_t;

  alu_state_t    st;
  lrx_op_t       op_r;
  logic [W-1:0]  opa;
  logic [W-1:0]  opb;
  logic [W-1:0]  acc;
  logic [CntW-1:0] cnt;
  logic          na;
  logic          nb;
  logic          dz;

  logic [W:0]    add_x;
  logic [W:0]    add_y;
  logic          add_cin;
  logic [W:0]    sum;
  logic [W-1:0]  rem_sh;
  logic          ge;
  logic          is_mul;
  logic          is_div;
  logic [W-1:0]  fix_val;
  logic          fix_neg;

  assign is_mul  = (op_r == OP_MUL);
  assign is_div  = (op_r == OP_DIV);
  assign rem_sh  = {acc[W-2:0], opa[W-1]};
  assign fix_val = is_div ? opa : acc;
  assign fix_neg = is_div ? (na ^ nb) : na;

  // operand select for the one shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    case (st)
      A_ADD: begin
        add_x   = {1'b0, opa};
        add_y   = {1'b0, (op_r == OP_SUB) ? ~opb : opb};
        add_cin = (op_r == OP_SUB);
      end
      A_NEGA: begin
        add_x   = {1'b0, ~opa};
        add_cin = 1'b1;
      end
      A_NEGB: begin
        add_x   = {1'b0, ~opb};
        add_cin = 1'b1;
      end
      A_LOOP: begin
        if (is_mul) begin
          add_x = {1'b0, acc};
          add_y = {1'b0, opb[0] ? opa : '0};
        end else begin
          add_x   = {1'b0, rem_sh};
          add_y   = {1'b1, ~opb};
          add_cin = 1'b1;
        end
      end
      A_FIX: begin
        add_x   = {1'b0, ~fix_val};
        add_cin = 1'b1;
      end
      default: begin
        add_x   = '0;
      end
    endcase
  end

  assign sum = add_x + add_y + (W+1)'(add_cin);
  assign ge  = ~sum[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= A_IDLE;
    end else begin
      case (st)
        A_IDLE: begin
          if (req.start) begin
            opa  <= a;
            opb  <= b;
            op_r <= req.op;
            na   <= a[W-1];
            nb   <= b[W-1];
            acc  <= '0;
            cnt  <= '0;
            dz   <= 1'b0;
            case (req.op)
              OP_ADD, OP_SUB: st <= A_ADD;
              OP_MUL:         st <= A_LOOP;
              OP_DIV, OP_MOD: begin
                if (b == '0) begin
                  result <= '0;
                  dz     <= 1'b1;
                  st     <= A_DONE;
                end else begin
                  st <= A_NEGA;
                end
              end
              default: begin
                result <= '0;
                st     <= A_DONE;
              end
            endcase
          end
        end
        A_ADD: begin
          result <= sum[W-1:0];
          st     <= A_DONE;
        end
        A_NEGA: begin
          if (na) begin
            opa <= sum[W-1:0];
          end
          st <= A_NEGB;
        end
        A_NEGB: begin
          if (nb) begin
            opb <= sum[W-1:0];
          end
          st <= A_LOOP;
        end
        A_LOOP: begin
          cnt <= cnt + 1'b1;
          if (is_mul) begin
            acc <= sum[W-1:0];
            opa <= {opa[W-2:0], 1'b0};
            opb <= {1'b0, opb[W-1:1]};
            if (cnt == LastStep) begin
              result <= sum[W-1:0];
              st     <= A_DONE;
            end
          end else begin
            acc <= ge ? sum[W-1:0] : rem_sh;
            opa <= {opa[W-2:0], ge};
            if (cnt == LastStep) begin
              st <= A_FIX;
            end
          end
        end
        A_FIX: begin
          result <= fix_neg ? sum[W-1:0] : fix_val;
          st     <= A_DONE;
        end
        A_DONE: begin
          st <= A_IDLE;
        end
        default: begin
          st <= A_IDLE;
        end
      endcase
    end
  end

  assign stat.done     = (st == A_DONE);
  assign stat.div_zero = dz;

endmodule

`default_nettype wire

/* sv/left_to_right_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// left_to_right_expression_evaluator
// character-serial infix calculator without precedence; digits build a
// number, operators fold it into the running value, the final character
// gives one result
// ----------------------------------------------------------------------------
//  channel | signals                          | transfer when
//  --------+----------------------------------+---------------------------
//  sym     | sym_valid, sym_ready, sym_data   | sym_valid && sym_ready
//  res     | res_valid, res_ready, res_data   | res_valid && res_ready
//
//  digits and ignored characters are absorbed in S_IDLE with sym_ready held
//  high; an operator after a left operand runs lrx_alu: add/sub via A_ADD,
//  multiply via the A_LOOP shift-add loop, divide/modulo via A_NEGA, A_NEGB,
//  A_LOOP and A_FIX; the loops handle one bit per cycle on the shared adder
//  a final character adds a pass through lrx_alu, started from the setup
//  state S_FIN_START, when an operator was seen (a lone number goes from
//  S_FIN_START straight to S_EMIT), then S_EMIT loads the result register
//  sync reset clears all expression state; no clearing pass
//  a held result register lets the next expression start; only a second
//  result waits for res_ready
// ----------------------------------------------------------------------------
`default_nettype none

module left_to_right_expression_evaluator #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sym_valid,
  output logic                   sym_ready,
  input  wire lrx_pkg::lrx_in_t  sym_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output lrx_pkg::lrx_out_t      res_data
);
  import lrx_pkg::*;

  localparam int unsigned W      = VALUE_WIDTH;
  localparam int unsigned NarrowW = (W < RES_WIDTH) ? W : RES_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_FIN_START,
    S_FIN_RUN,
    S_EMIT
  } state_t;

  state_t        st;
  logic [W-1:0]  number_accum;
  logic [W-1:0]  running_value;
  logic          have_left;
  lrx_op_t       pending_op;
  logic          zero_div_seen;
  lrx_op_t       op_new;
  logic          fin_pend;

  // decode of the incoming character
  logic          accept;
  logic          is_digit;
  lrx_op_t       in_op;
  logic [W-1:0]  digit_ext;
  logic [W-1:0]  accum_next;
  logic          out_free;

  // shared arithmetic unit
  lrx_req_t      alu_req;
  logic [W-1:0]  alu_res;
  lrx_stat_t     alu_stat;

  assign sym_ready = (st == S_IDLE);
  assign accept    = sym_valid && sym_ready;
  assign is_digit  = (sym_data.symbol >= CHAR_ZERO) && (sym_data.symbol <= CHAR_NINE);
  assign in_op     = sym_op(sym_data.symbol);
  // low nibble of an ascii digit is its value
  assign digit_ext = W'(sym_data.symbol[3:0]);
  // times ten as two shifted copies, wrapping at W bits
  assign accum_next = {number_accum[W-4:0], 3'b000} + {number_accum[W-2:0], 1'b0}
                      + digit_ext;
  assign out_free  = !res_valid || res_ready;

  // start a fold on an operator with a left operand, or the final pass
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = pending_op;
    if (accept && !is_digit && (in_op != OP_NONE) && have_left) begin
      alu_req.start = 1'b1;
    end else if ((st == S_FIN_START) && have_left) begin
      alu_req.start = 1'b1;
    end
  end

  lrx_alu #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (running_value),
    .b      (number_accum),
    .result (alu_res),
    .stat   (alu_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      number_accum  <= '0;
      running_value <= '0;
      have_left     <= 1'b0;
      pending_op    <= OP_NONE;
      zero_div_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      // result register drains independently of the sequencer
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            fin_pend <= sym_data.is_final;
            if (is_digit) begin
              number_accum <= accum_next;
              if (sym_data.is_final) begin
                st <= S_FIN_START;
              end
            end else if (in_op != OP_NONE) begin
              if (have_left) begin
                // fold runs in lrx_alu, finish in S_FOLD
                op_new <= in_op;
                st     <= S_FOLD;
              end else begin
                running_value <= number_accum;
                have_left     <= 1'b1;
                pending_op    <= in_op;
                number_accum  <= '0;
                if (sym_data.is_final) begin
                  st <= S_FIN_START;
                end
              end
            end else if (sym_data.is_final) begin
              st <= S_FIN_START;
            end
          end
        end
        S_FOLD: begin
          if (alu_stat.done) begin
            running_value <= alu_res;
            zero_div_seen <= zero_div_seen | alu_stat.div_zero;
            have_left     <= 1'b1;
            pending_op    <= op_new;
            number_accum  <= '0;
            st            <= fin_pend ? S_FIN_START : S_IDLE;
          end
        end
        S_FIN_START: begin
          if (have_left) begin
            st <= S_FIN_RUN;
          end else begin
            // lone number is the result
            running_value <= number_accum;
            st            <= S_EMIT;
          end
        end
        S_FIN_RUN: begin
          if (alu_stat.done) begin
            running_value <= alu_res;
            zero_div_seen <= zero_div_seen | alu_stat.div_zero;
            st            <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res_data.value       <= RES_WIDTH'(running_value[NarrowW-1:0]);
            res_data.div_by_zero <= zero_div_seen;
            res_valid            <= 1'b1;
            number_accum         <= '0;
            running_value        <= '0;
            have_left            <= 1'b0;
            pending_op           <= OP_NONE;
            zero_div_seen        <= 1'b0;
            st                   <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/tb_left_to_right_expression_evaluator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_left_to_right_expression_evaluator
// self-checking bench: streams expression characters into the evaluator,
// predicts each result in the bench and checks every returned result
// field by field under random idling on both sides and long output stalls
// ----------------------------------------------------------------------------

module tb_left_to_right_expression_evaluator;

  import lrx_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 2 * (RES_WIDTH + 5) + 16;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_SYMBOLS = 1400;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     sym_valid = 1'b0;
  logic     sym_ready;
  lrx_in_t  sym_data  = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  lrx_out_t res_data;

  left_to_right_expression_evaluator #(
    .VALUE_WIDTH(RES_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .sym_valid(sym_valid),
    .sym_ready(sym_ready),
    .sym_data (sym_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // evaluation state mirrored in the bench
  // ---------------------------------------------------------------------------
  logic [RES_WIDTH-1:0] acc_number    = '0;
  logic [RES_WIDTH-1:0] acc_running   = '0;
  logic                 acc_have_left = 1'b0;
  lrx_op_t              acc_pending   = OP_NONE;
  logic                 acc_div_zero  = 1'b0;

  // results still owed by the evaluator, oldest first
  lrx_out_t expected_results[$];
  // characters of the expression being assembled for sending
  logic [7:0] sym_pend[$];

  int unsigned n_syms    = 0;  // every accepted character
  int unsigned n_active  = 0;  // digits and operators only
  int unsigned n_exprs   = 0;
  int unsigned n_dz      = 0;
  int unsigned n_checked = 0;
  int unsigned n_err     = 0;

  // idling limits, changed per phase
  int unsigned tx_max = 16;
  int unsigned rx_max = 16;

  // receiver hold-off request, bumped by a test
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_wait   = 0;

  int unsigned quiet_cycles = 0;
  lrx_out_t    want;

  // apply one binary operation, 32-bit wrapping, truncating divide
  function automatic logic [RES_WIDTH-1:0] fold_operand(input logic [RES_WIDTH-1:0] lhs,
                                                        input logic [RES_WIDTH-1:0] rhs,
                                                        input lrx_op_t op);
    logic [RES_WIDTH-1:0] mag_l;
    logic [RES_WIDTH-1:0] mag_r;
    logic [RES_WIDTH-1:0] quo;
    logic [RES_WIDTH-1:0] rem;
    logic [RES_WIDTH-1:0] r;
    r = '0;
    case (op)
      OP_ADD: r = lhs + rhs;
      OP_SUB: r = lhs - rhs;
      OP_MUL: r = lhs * rhs;
      OP_DIV, OP_MOD: begin
        if (rhs == '0) begin
          // divide or modulo by zero gives 0 and is flagged
          acc_div_zero = 1'b1;
        end else begin
          mag_l = lhs[RES_WIDTH-1] ? -lhs : lhs;
          mag_r = rhs[RES_WIDTH-1] ? -rhs : rhs;
          quo   = mag_l / mag_r;
          rem   = mag_l % mag_r;
          if (op == OP_DIV) begin
            r = (lhs[RES_WIDTH-1] ^ rhs[RES_WIDTH-1]) ? -quo : quo;
          end else begin
            r = lhs[RES_WIDTH-1] ? -rem : rem;
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // update the mirrored state with one accepted character
  function automatic void eval_symbol(input logic [7:0] s, input logic f);
    lrx_op_t  op;
    lrx_out_t res;
    case (s)
      CHAR_PLUS:  op = OP_ADD;
      CHAR_MINUS: op = OP_SUB;
      CHAR_STAR:  op = OP_MUL;
      CHAR_SLASH: op = OP_DIV;
      CHAR_PCT:   op = OP_MOD;
      default:    op = OP_NONE;
    endcase
    n_syms++;
    if (s >= CHAR_ZERO && s <= CHAR_NINE) begin
      acc_number = acc_number * 10 + (s - CHAR_ZERO);
      n_active++;
    end else if (op != OP_NONE) begin
      // an empty number counts as 0, the first operator just latches it
      acc_running   = acc_have_left ? fold_operand(acc_running, acc_number, acc_pending)
                                    : acc_number;
      acc_have_left = 1'b1;
      acc_pending   = op;
      acc_number    = '0;
      n_active++;
    end
    if (f) begin
      res.value       = acc_have_left ? fold_operand(acc_running, acc_number, acc_pending)
                                      : acc_number;
      res.div_by_zero = acc_div_zero;
      expected_results.push_back(res);
      n_exprs++;
      if (acc_div_zero) begin
        n_dz++;
      end
      acc_number    = '0;
      acc_running   = '0;
      acc_have_left = 1'b0;
      acc_pending   = OP_NONE;
      acc_div_zero  = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // one character transfer; valid stays high into the next call when no gap
  task automatic send_sym(input logic [7:0] s, input logic f);
    int unsigned gap;
    gap = (tx_max == 0) ? 0 : $urandom_range(tx_max, 0);
    if (gap > 0) begin
      sym_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_valid <= 1'b1;
    sym_data  <= {s, f};
    do @(posedge clk); while (!sym_ready);
    eval_symbol(s, f);
  endtask

  task automatic queue_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      sym_pend.push_back(txt[i]);
    end
  endtask

  // send the assembled characters, final flag on the last one
  task automatic send_pending();
    int unsigned n;
    n = sym_pend.size();
    for (int i = 0; i < n; i++) begin
      send_sym(sym_pend[i], i == n - 1);
    end
    sym_pend.delete();
  endtask

  task automatic send_text(input string txt);
    queue_text(txt);
    send_pending();
  endtask

  // sender pauses until every owed result is back, then lets the block settle
  task automatic wait_drained();
    sym_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed expressions with random operands; some noise,
  // empty numbers, trailing operators and long wrapping numbers
  task automatic send_random_expr();
    int unsigned n_opnd;
    int unsigned kind;
    int unsigned nd;
    logic [7:0]  op_ch;
    if ($urandom_range(9, 0) == 0) begin
      n_opnd = $urandom_range(6, 1);
      repeat (n_opnd) sym_pend.push_back(8'($urandom_range(255, 0)));
    end else begin
      n_opnd = $urandom_range(5, 1);
      for (int i = 0; i < n_opnd; i++) begin
        if (i > 0) begin
          case ($urandom_range(4, 0))
            0:       op_ch = CHAR_PLUS;
            1:       op_ch = CHAR_MINUS;
            2:       op_ch = CHAR_STAR;
            3:       op_ch = CHAR_SLASH;
            default: op_ch = CHAR_PCT;
          endcase
          sym_pend.push_back(op_ch);
        end
        kind = $urandom_range(15, 0);
        if (kind == 2) begin
          // values around the signed limits and a wrapped minus one
          case ($urandom_range(4, 0))
            0:       queue_text("2147483648");
            1:       queue_text("2147483647");
            2:       queue_text("4294967295");
            3:       queue_text("12884901887");
            default: queue_text("0");
          endcase
        end else begin
          nd = (kind == 0) ? 0 : (kind == 1) ? $urandom_range(13, 10) : $urandom_range(3, 1);
          repeat (nd) sym_pend.push_back(CHAR_ZERO + 8'($urandom_range(9, 0)));
        end
        if ($urandom_range(11, 0) == 0) begin
          sym_pend.push_back(8'($urandom_range(255, 0)));
        end
      end
      // end on an operator or a stray character now and then
      if ($urandom_range(7, 0) == 0) begin
        sym_pend.push_back($urandom_range(1, 0) ? CHAR_SLASH : 8'($urandom_range(255, 0)));
      end
    end
    send_pending();
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall per result, plus long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rx_wait = 0;
      res_ready <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (res_valid && res_ready) begin
        rx_wait = (rx_max == 0) ? 0 : $urandom_range(rx_max, 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // result check against the oldest owed result
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing owed: value %0d div_by_zero %0b",
               $signed(res_data.value), res_data.div_by_zero);
        n_err++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (res_data.value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(res_data.value));
          n_err++;
        end
        if (res_data.div_by_zero !== want.div_by_zero) begin
          $error("div_by_zero: expected %0b, got %0b", want.div_by_zero, res_data.div_by_zero);
          n_err++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (sym_valid && sym_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("timeout after %0d quiet cycles, %0d results owed",
             quiet_cycles, expected_results.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every operator, symbol extremes, empty and lone numbers, sign of results
  task automatic test_directed();
    send_text("9");
    send_sym(8'hff, 1'b0);
    send_sym(8'h00, 1'b1);
    send_text("5+");
    send_text("3-4");
    send_text("6*7");
    send_text("9/0");
    send_text("9%4");
    send_text("-7/2");
    send_text("-7%2");
  endtask

  // most negative over minus one, with the divisor wrapping while built
  task automatic test_wrap_corners();
    send_text("2147483648/12884901887");
    send_text("2147483648%12884901887");
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    tx_max = 0;
    rx_max = 0;
    hold_seq++;
    repeat (30) send_random_expr();
    wait_drained();
  endtask

  // sender stops until every result is back, several times
  task automatic test_drain_pause();
    tx_max = 16;
    rx_max = 16;
    repeat (3) begin
      repeat (5) send_random_expr();
      wait_drained();
    end
  endtask

  // bulk random expressions, idling mix redrawn every few dozen
  task automatic test_random();
    int unsigned start;
    int unsigned k;
    start = n_active;
    k     = 0;
    while (n_active - start < RANDOM_SYMBOLS) begin
      if (k % 40 == 0) begin
        tx_max = $urandom_range(1, 0) ? 16 : 0;
        rx_max = $urandom_range(1, 0) ? 16 : 0;
      end
      send_random_expr();
      k++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_wrap_corners();
    test_backpressure();
    test_drain_pause();
    test_random();
    wait_drained();
    $display("covered %0d characters (%0d digits or operators) in %0d expressions",
             n_syms, n_active, n_exprs);
    $display("checked %0d results, %0d with divide by zero, %0d mismatches",
             n_checked, n_dz, n_err);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
